@@ design/pixel_cluster_centroid_core_assert.svh @@
// Assertion macros for the pixel cluster centroid core.
`ifndef PIXEL_CLUSTER_CENTROID_CORE_ASSERT_SVH
`define PIXEL_CLUSTER_CENTROID_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define PCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pixel cluster centroid check failed");
// Next-cycle implication
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pixel cluster centroid check failed");
`else
`define PCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/pcc_pkg.sv @@
// Shared types, constants and coordinate maps of the pixel cluster centroid core.
package pcc_pkg;

	// Quotient bits of the shift divider
	localparam int QW = 24;

	// Highest valid column index
	localparam logic [4:0] COL_LAST = 5'd17;

	// Bit positions in cluster_status
	localparam int STAT_BAD_COL  = 0;
	localparam int STAT_OVERFLOW = 1;

	// Saturation bounds of the shift results
	localparam logic signed [QW-1:0] SHIFT_MAX = 24'sh7FFFFF;
	localparam logic signed [QW-1:0] SHIFT_MIN = 24'sh800000;

	// Controller to datapath commands
	typedef struct packed {
		logic take;      // accept the item on the input ports
		logic axis;      // 0: x, 1: y
		logic ld_mul;    // seed times signal sum
		logic ld_prep;   // form divider numerator and divisor
		logic div_init;  // overflow check and first partial remainder
		logic div_step;  // one restoring division step
		logic store;     // store the finished shift of the selected axis
		logic emit;      // present the result, clear the cluster
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pipe_busy; // pixels still in the accumulate pipeline
	} stat_t;

	// Column index to x in micrometres (valid columns only)
	function automatic logic [12:0] col_to_x(input logic [4:0] col);
		logic [12:0] x;
		if (col == 5'd0) begin
			x = 13'd300;
		end else if (col == COL_LAST) begin
			x = 13'd7300;
		end else begin
			x = 13'd400 + 13'd400 * {8'd0, col};
		end
		return x;
	endfunction

	// Row index to y in micrometres
	function automatic logic [13:0] row_to_y(input logic [7:0] row);
		return 14'd25 + 14'd50 * {6'd0, row};
	endfunction

endpackage

@@ design/pcc_ctrl.sv @@
// Controller of the pixel cluster centroid core: intake, drain and shift sequencing.
module pcc_ctrl
	import pcc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  last_pixel,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_MUL,
		ST_PREP,
		ST_CHK,
		ST_DIV,
		ST_STORE,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic        busy_q;
	logic        axis_q;
	logic [4:0]  iter_q;

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.take     = start & ~busy_q;
		cmd.axis     = axis_q;
		cmd.ld_mul   = (state_q == ST_MUL);
		cmd.ld_prep  = (state_q == ST_PREP);
		cmd.div_init = (state_q == ST_CHK);
		cmd.div_step = (state_q == ST_DIV);
		cmd.store    = (state_q == ST_STORE);
		cmd.emit     = (state_q == ST_EMIT);
	end

	assign busy = busy_q;

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			axis_q  <= 1'b0;
			iter_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && !busy_q && last_pixel) begin
						state_q <= ST_DRAIN;
						busy_q  <= 1'b1;
						axis_q  <= 1'b0;
					end
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= ST_DIV;
					iter_q  <= '0;
				end
				ST_DIV: begin
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'(QW - 1)) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					axis_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ design/pcc_datapath.sv @@
// Datapath of the pixel cluster centroid core: accumulation, seed, shared shift divider.
module pcc_datapath
	import pcc_pkg::*;
#(
	parameter int MAX_PIXELS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [4:0]           column_index,
	input  logic [7:0]           row_index,
	input  logic signed [15:0]   pixel_signal,
	output logic                 done,
	output logic [12:0]          seed_x_um,
	output logic [13:0]          seed_y_um,
	output logic signed [QW-1:0] shift_x,
	output logic signed [QW-1:0] shift_y,
	output logic [1:0]           cluster_status
);

	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W = 16 + CNT_W;
	localparam int WX_W  = SUM_W + 13;
	localparam int WY_W  = SUM_W + 14;
	localparam int PR_W  = SUM_W + 15;
	localparam int DF_W  = SUM_W + 16;
	localparam int NW    = DF_W + 10;
	localparam int DW    = SUM_W + 1;
	localparam int HI_W  = NW - QW;

	// cluster state
	logic [CNT_W-1:0]        cnt_q;
	logic [1:0]              flags_q;
	logic signed [15:0]      best_sig_q;
	logic [12:0]             best_x_q;
	logic [13:0]             best_y_q;
	logic signed [WX_W-1:0]  wx_q;
	logic signed [WY_W-1:0]  wy_q;
	logic signed [SUM_W-1:0] ssum_q;

	// accumulate pipeline
	logic                    v_s1;
	logic                    first_s1;
	logic signed [15:0]      sig_s1;
	logic [12:0]             x_s1;
	logic [13:0]             y_s1;
	logic                    v_s2;
	logic signed [29:0]      px_s2;
	logic signed [30:0]      py_s2;
	logic signed [15:0]      sig_s2;

	// shift computation
	logic signed [PR_W-1:0]  w_q;
	logic signed [PR_W-1:0]  prod_q;
	logic [NW-1:0]           n_q;
	logic [DW-1:0]           d_q;
	logic                    neg_q;
	logic                    ovf_q;
	logic [DW-1:0]           rem_q;
	logic [QW-1:0]           nlo_q;
	logic [QW-1:0]           q_q;

	// result registers
	logic                    done_q;
	logic [12:0]             seed_x_q;
	logic [13:0]             seed_y_q;
	logic signed [QW-1:0]    shift_x_q;
	logic signed [QW-1:0]    shift_y_q;
	logic [1:0]              status_q;

	logic                    col_bad;
	logic                    full;
	logic                    use_pix;
	logic signed [PR_W-1:0]  w_sel;
	logic [13:0]             seed_sel;
	logic signed [DF_W-1:0]  diff;
	logic [DF_W-1:0]         an;
	logic [SUM_W-1:0]        ad;
	logic [DW:0]             rem2;
	logic                    ge;
	logic                    zero_shift;
	logic signed [QW-1:0]    shift_res;

	// intake classification
	assign col_bad = column_index > COL_LAST;
	assign full    = cnt_q >= CNT_W'(MAX_PIXELS);
	assign use_pix = cmd.take && !col_bad && !full;

	assign stat.pipe_busy = v_s1 | v_s2;

	// counter, flags, seed and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			flags_q    <= '0;
			best_sig_q <= 16'sh8000;
			best_x_q   <= '0;
			best_y_q   <= '0;
			wx_q       <= '0;
			wy_q       <= '0;
			ssum_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else if (cmd.emit) begin
			cnt_q      <= '0;
			flags_q    <= '0;
			best_sig_q <= 16'sh8000;
			best_x_q   <= '0;
			best_y_q   <= '0;
			wx_q       <= '0;
			wy_q       <= '0;
			ssum_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			if (cmd.take && col_bad) begin
				flags_q[STAT_BAD_COL] <= 1'b1;
			end else if (cmd.take && full) begin
				flags_q[STAT_OVERFLOW] <= 1'b1;
			end
			if (use_pix) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			v_s1 <= use_pix;
			v_s2 <= v_s1;
			// seed: first pixel, or strictly stronger
			if (v_s1 && (first_s1 || sig_s1 > best_sig_q)) begin
				best_sig_q <= sig_s1;
				best_x_q   <= x_s1;
				best_y_q   <= y_s1;
			end
			if (v_s2) begin
				wx_q   <= wx_q + WX_W'(px_s2);
				wy_q   <= wy_q + WY_W'(py_s2);
				ssum_q <= ssum_q + SUM_W'(sig_s2);
			end
		end
	end

	// pipeline payload: map coordinates, then weight them
	always_ff @(posedge clk) begin
		if (use_pix) begin
			first_s1 <= (cnt_q == '0);
			sig_s1   <= pixel_signal;
			x_s1     <= col_to_x(column_index);
			y_s1     <= row_to_y(row_index);
		end
		if (v_s1) begin
			px_s2  <= 30'(sig_s1) * 30'($signed({1'b0, x_s1}));
			py_s2  <= 31'(sig_s1) * 31'($signed({1'b0, y_s1}));
			sig_s2 <= sig_s1;
		end
	end

	// operand selection for the shared shift unit
	assign w_sel    = cmd.axis ? PR_W'(wy_q) : PR_W'(wx_q);
	assign seed_sel = cmd.axis ? best_y_q : {1'b0, best_x_q};
	assign diff     = DF_W'(w_q) - DF_W'(prod_q);
	assign an       = diff[DF_W-1] ? DF_W'(-diff) : DF_W'(diff);
	assign ad       = ssum_q[SUM_W-1] ? SUM_W'(-ssum_q) : SUM_W'(ssum_q);

	// restoring division step
	assign rem2 = {rem_q, nlo_q[QW-1]};
	assign ge   = rem2 >= {1'b0, d_q};

	// rounding already folded in; saturate and apply sign
	assign zero_shift = (ssum_q == '0) || (cnt_q <= CNT_W'(1));
	always_comb begin
		if (zero_shift) begin
			shift_res = '0;
		end else if (ovf_q || q_q[QW-1]) begin
			shift_res = neg_q ? SHIFT_MIN : SHIFT_MAX;
		end else if (neg_q) begin
			shift_res = -$signed(q_q);
		end else begin
			shift_res = $signed(q_q);
		end
	end

	// shift unit registers
	always_ff @(posedge clk) begin
		if (cmd.ld_mul) begin
			w_q    <= w_sel;
			prod_q <= PR_W'($signed({1'b0, seed_sel})) * PR_W'(ssum_q);
		end
		if (cmd.ld_prep) begin
			n_q   <= NW'({an, 9'd0}) + NW'(ad);
			d_q   <= {ad, 1'b0};
			neg_q <= diff[DF_W-1] ^ ssum_q[SUM_W-1];
		end
		if (cmd.div_init) begin
			ovf_q <= n_q[NW-1:QW] >= HI_W'(d_q);
			rem_q <= n_q[QW+DW-1:QW];
			nlo_q <= n_q[QW-1:0];
			q_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? DW'(rem2 - {1'b0, d_q}) : rem2[DW-1:0];
			nlo_q <= {nlo_q[QW-2:0], 1'b0};
			q_q   <= {q_q[QW-2:0], ge};
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.store && !cmd.axis) begin
			shift_x_q <= shift_res;
		end
		if (cmd.store && cmd.axis) begin
			shift_y_q <= shift_res;
		end
		if (cmd.emit) begin
			seed_x_q <= best_x_q;
			seed_y_q <= best_y_q;
			status_q <= flags_q;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign done           = done_q;
	assign seed_x_um      = seed_x_q;
	assign seed_y_um      = seed_y_q;
	assign shift_x        = shift_x_q;
	assign shift_y        = shift_y_q;
	assign cluster_status = status_q;

endmodule

@@ design/pixel_cluster_centroid_core.sv @@
// Top level of the pixel cluster centroid core: controller plus datapath.
//
// Usage:
//   Pixels of one cluster enter on column_index, row_index, pixel_signal and
//   last_pixel; an item is taken at a clock edge with start high and busy low.
//   Pixels that are not last are taken every cycle, busy stays low.
//   The last pixel raises busy. The block drains its two-stage accumulate
//   pipeline, then runs the shared 24-step restoring divider once for x and
//   once for y. The result (seed_x_um, seed_y_um, shift_x, shift_y,
//   cluster_status) is shown for one cycle with done high; busy is low again
//   in that cycle, so the next cluster may start at once.
//   The receiver cannot hold results off; it must take done when it comes.
//   Reset (arst_n low) clears the cluster state, the controller and done.
//   Columns above 17 and pixels beyond MAX_PIXELS are dropped and flagged in
//   cluster_status; their last marker still closes the cluster.
`include "pixel_cluster_centroid_core_assert.svh"
module pixel_cluster_centroid_core
	import pcc_pkg::*;
#(
	parameter int MAX_PIXELS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [4:0]           column_index,
	input  logic [7:0]           row_index,
	input  logic signed [15:0]   pixel_signal,
	input  logic                 last_pixel,
	output logic                 done,
	output logic [12:0]          seed_x_um,
	output logic [13:0]          seed_y_um,
	output logic signed [QW-1:0] shift_x,
	output logic signed [QW-1:0] shift_y,
	output logic [1:0]           cluster_status
);

	cmd_t  cmd;
	stat_t stat;

	pcc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_pixel (last_pixel),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy)
	);

	pcc_datapath #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.column_index   (column_index),
		.row_index      (row_index),
		.pixel_signal   (pixel_signal),
		.done           (done),
		.seed_x_um      (seed_x_um),
		.seed_y_um      (seed_y_um),
		.shift_x        (shift_x),
		.shift_y        (shift_y),
		.cluster_status (cluster_status)
	);

	// busy only rises after a last pixel was taken
	`PCC_ASSERT_IMPL(a_busy_rise, clk, arst_n, $rose(busy), $past(start && last_pixel))
	// the shift computation starts on a drained pipeline only
	`PCC_ASSERT_IMPL(a_mul_drained, clk, arst_n, cmd.ld_mul, !stat.pipe_busy)
	// each cluster end gives one result strobe, one cycle long
	`PCC_ASSERT_NEXT(a_emit_done, clk, arst_n, cmd.emit, done && !busy)
	`PCC_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

endmodule
